// ===== rtl/uampq_pkg.sv =====
// shared types and constants for the unsorted-store max priority queue
// no dependencies; imported by the compare unit, the top level, the checker and the testbench

package uampq_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 11;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic valid;
        logic first;
    } sample_ctl_t;

endpackage

// ===== rtl/unsorted_array_max_priority_queue_unit.sv =====
// top level: sequencer, entry count and result register of the max priority queue
// depends on uampq_pkg, uampq_ram and uampq_max_unit
//
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  cmd, value
// rsp       out        rsp_valid/rsp_stall  result_value, status, occupancy
//
// an insert item goes from idle to the done state, where its result is loaded into the result register once rsp is free
// a remove item of n entries scans all n entries, then passes through the drain, move and done states
// remove reads the entry store one entry a cycle through its single read port
// reset clears the count and control state; no clearing pass on the store
// req is stalled while an item is in progress; rsp stall holds the result
// register, and a new item may be taken while a result waits

module unsorted_array_max_priority_queue_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          cmd,
    input  logic [uampq_pkg::VALUE_W-1:0] value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [uampq_pkg::VALUE_W-1:0] result_value,
    output uampq_pkg::status_t            status,
    output logic [uampq_pkg::OCC_W-1:0]   occupancy
);

    import uampq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MOVE,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_first_reg, rd_first_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [VALUE_W-1:0] last_val_reg, last_val_next;
    logic [VALUE_W-1:0] res_val_reg, res_val_next;
    status_t            res_status_reg, res_status_next;
    logic [VALUE_W-1:0] out_val_reg, out_val_next;
    status_t            out_status_reg, out_status_next;
    logic [OCC_W-1:0]   out_occ_reg, out_occ_next;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic [VALUE_W-1:0] rdata;
    logic [IDX_W-1:0]   last_idx;
    logic [VALUE_W-1:0] best_val;
    logic [IDX_W-1:0]   best_idx;
    sample_ctl_t        sample_ctl;
    logic               full;
    logic               rsp_free;

    uampq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (scan_idx_reg),
        .rdata (rdata)
    );

    assign sample_ctl.valid = rd_pend_reg;
    assign sample_ctl.first = rd_first_reg;

    uampq_max_unit #(
        .IDX_W (IDX_W)
    ) u_max (
        .clk      (clk),
        .ctl      (sample_ctl),
        .idx      (rd_idx_reg),
        .data     (rdata),
        .best_val (best_val),
        .best_idx (best_idx)
    );

    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign last_idx = IDX_W'(cnt_reg - CNT_W'(1));
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = 1'b0;
        rd_first_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        last_val_next   = last_val_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        out_val_next    = out_val_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        we              = 1'b0;
        waddr           = IDX_W'(cnt_reg);
        wdata           = value;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_val_next    = '0;
                    res_status_next = STATUS_OK;
                    state_next      = S_DONE;
                    if (cmd == CMD_INSERT)
                    begin
                        if (full)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            we       = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_pend_next  = 1'b1;
                rd_first_next = (scan_idx_reg == '0);
                rd_idx_next   = scan_idx_reg;
                if (scan_idx_reg == last_idx)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                // read data here belongs to the last stored entry
                last_val_next = rdata;
                state_next    = S_MOVE;
            end
            S_MOVE:
            begin
                we              = 1'b1;
                waddr           = best_idx;
                wdata           = last_val_reg;
                cnt_next        = cnt_reg - CNT_W'(1);
                res_val_next    = best_val;
                res_status_next = STATUS_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    out_val_next    = res_val_reg;
                    out_status_next = res_status_reg;
                    out_occ_next    = OCC_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            rd_first_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_first_reg  <= rd_first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        last_val_reg   <= last_val_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        out_val_reg    <= out_val_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign result_value = out_val_reg;
    assign status       = out_status_reg;
    assign occupancy    = out_occ_reg;

endmodule

// ===== rtl/uampq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; used for the entry store

module uampq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/uampq_max_unit.sv =====
// signed compare unit tracking the running maximum and its index
// depends on uampq_pkg for the sample control struct and the value width

module uampq_max_unit #(
    parameter int IDX_W = 10
) (
    input  logic                        clk,
    input  uampq_pkg::sample_ctl_t      ctl,
    input  logic [IDX_W-1:0]            idx,
    input  logic [uampq_pkg::VALUE_W-1:0] data,
    output logic [uampq_pkg::VALUE_W-1:0] best_val,
    output logic [IDX_W-1:0]            best_idx
);

    import uampq_pkg::*;

    logic [VALUE_W-1:0] best_val_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               take;

    // strict greater-than keeps the lowest index on ties
    assign take = ctl.valid && (ctl.first || ($signed(data) > $signed(best_val_reg)));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_val_reg <= data;
            best_idx_reg <= idx;
        end
    end

    assign best_val = best_val_reg;
    assign best_idx = best_idx_reg;

endmodule

// ===== dv/uampq_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the unsorted-store max priority queue: predicts each response item
// from the accepted request items and compares them in order of arrival
// depends on uampq_pkg; instantiated beside the block by the testbench top

module uampq_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic                          cmd,
    input  logic [uampq_pkg::VALUE_W-1:0] value,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [uampq_pkg::VALUE_W-1:0] result_value,
    input  uampq_pkg::status_t            status,
    input  logic [uampq_pkg::OCC_W-1:0]   occupancy,
    output int                            mismatch_count,
    output int                            pending_count
);

    import uampq_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] max_value;
        status_t            code;
        logic [OCC_W-1:0]   fill;
    } queue_result_t;

    logic [VALUE_W-1:0] shadow_store [CAPACITY];
    int                 shadow_count = 0;
    int                 failures = 0;
    queue_result_t      pending_results [$];

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    function automatic queue_result_t apply_queue_op(input logic op,
                                                     input logic [VALUE_W-1:0] operand);
        queue_result_t res;
        int            best;
        res.max_value = '0;
        res.code      = STATUS_OK;
        if (op == CMD_INSERT)
        begin
            if (shadow_count >= CAPACITY)
                res.code = STATUS_FULL;
            else
            begin
                shadow_store[shadow_count] = operand;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            res.code = STATUS_EMPTY;
        else
        begin
            // linear search, ties keep the lowest index
            best = 0;
            for (int j = 1; j < shadow_count; j++)
                if ($signed(shadow_store[j]) > $signed(shadow_store[best]))
                    best = j;
            res.max_value      = shadow_store[best];
            shadow_store[best] = shadow_store[shadow_count - 1];
            shadow_count--;
        end
        res.fill = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        queue_result_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            pending_results.delete();
            pending_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected item: value %0d status %0d occupancy %0d",
                                 $signed(result_value), status, occupancy);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.max_value !== result_value || want.code !== status
                        || want.fill !== occupancy)
                    begin
                        if (failures < 10)
                        begin
                            $write("mismatch: expected value %0d status %0d occupancy %0d,",
                                   $signed(want.max_value), want.code, want.fill);
                            $display(" got value %0d status %0d occupancy %0d",
                                     $signed(result_value), status, occupancy);
                        end
                        failures++;
                    end
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(apply_queue_op(cmd, value));
            pending_count <= pending_results.size();
        end
        mismatch_count <= failures;
    end

endmodule

// ===== dv/tb_unsorted_array_max_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// testbench top for unsorted_array_max_priority_queue_unit: sends request items in
// bursts, stalls responses on its own pattern and gives the verdict
// depends on uampq_pkg, the block and uampq_checker

module tb_unsorted_array_max_priority_queue_unit;

    import uampq_pkg::*;

    localparam int QUEUE_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 580;
    localparam int IDLE_LIMIT   = 20000;
    localparam int TAIL_CYCLES  = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic               cmd       = CMD_INSERT;
    logic [VALUE_W-1:0] value     = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [VALUE_W-1:0] result_value;
    status_t            status;
    logic [OCC_W-1:0]   occupancy;

    int                 mismatch_count;
    int                 pending_count;
    int                 level       = 0;
    int                 burst_left  = 0;
    int                 idle_cycles = 0;
    int                 stall_mode  = 0;
    int                 stall_left  = 0;
    logic [VALUE_W-1:0] last_value  = '0;

    always #1 clk = ~clk;

    unsorted_array_max_priority_queue_unit #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_value (result_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    uampq_checker #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .cmd            (cmd),
        .value          (value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result_value   (result_value),
        .status         (status),
        .occupancy      (occupancy),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // response stall: free-running, lightly stalled or heavily stalled stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(8, 80);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            4:       return last_value;
            5:       return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    task automatic put_item(input logic op, input logic [VALUE_W-1:0] operand);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        req_valid <= 1'b1;
        cmd       <= op;
        value     <= operand;
        do
            @(posedge clk);
        while (req_stall);
        burst_left--;
        if (op == CMD_INSERT)
        begin
            last_value = operand;
            if (level < QUEUE_DEPTH)
                level++;
        end
        else if (level > 0)
            level--;
    endtask

    task automatic drain_queue_results();
        req_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    initial
    begin : stimulus
        logic op;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, signed extremes, equal maxima
        put_item(CMD_REMOVE, 32'h1234_5678);
        put_item(CMD_INSERT, 32'h7fff_ffff);
        put_item(CMD_INSERT, 32'h8000_0000);
        put_item(CMD_INSERT, 32'h0000_0000);
        put_item(CMD_INSERT, 32'hffff_ffff);
        put_item(CMD_INSERT, 32'h7fff_ffff);
        put_item(CMD_INSERT, 32'h0000_0001);
        repeat (7) put_item(CMD_REMOVE, 32'hffff_ffff);
        put_item(CMD_INSERT, 32'h8000_0000);
        put_item(CMD_INSERT, 32'h8000_0000);
        put_item(CMD_INSERT, 32'h0000_0005);
        put_item(CMD_INSERT, 32'h0000_0005);
        repeat (4) put_item(CMD_REMOVE, 32'h0000_0000);
        put_item(CMD_REMOVE, 32'h5555_5555);

        // random mix, kept shallow so that removes stay short
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_queue_results();
            if (level < 4)
                op = ($urandom_range(0, 9) < 7) ? CMD_INSERT : CMD_REMOVE;
            else if (level > 48)
                op = ($urandom_range(0, 9) < 3) ? CMD_INSERT : CMD_REMOVE;
            else
                op = ($urandom_range(0, 9) < 5) ? CMD_INSERT : CMD_REMOVE;
            put_item(op, pick_value());
        end

        // fill to capacity, push against full, then work around the top
        drain_queue_results();
        while (level < QUEUE_DEPTH)
            put_item(CMD_INSERT, pick_value());
        repeat (4) put_item(CMD_INSERT, pick_value());
        repeat (24) put_item($urandom_range(0, 1) ? CMD_REMOVE : CMD_INSERT, pick_value());

        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
